>>> hw/rtl/fat32_boot_sector_parser_top_macros.svh
// Assertion helpers for the boot sector parser.
`ifndef FAT32_BOOT_SECTOR_PARSER_TOP_MACROS_SVH
`define FAT32_BOOT_SECTOR_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define FBSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbsp assertion failed");

// Next-cycle implication, checked out of reset.
`define FBSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbsp assertion failed");

`else

`define FBSP_ASSERT_NOW(label, clk, rst, ante, cons)
`define FBSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/fbsp_pkg.sv
`timescale 1ns / 1ps

package fbsp_pkg;

  // Sector summaries waiting between front and back end
  localparam int FBSP_QUEUE_DEPTH = 2;

  localparam logic [9:0]  POS_LAST_COUNT = 10'd1023;
  localparam logic [9:0]  POS_SECTOR_END = 10'd512;
  localparam logic [9:0]  POS_PART_TABLE = 10'd446;
  localparam logic [9:0]  POS_SIG_LO     = 10'd510;
  localparam logic [9:0]  POS_SIG_HI     = 10'd511;
  localparam logic [7:0]  TYPE_FAT32_CHS = 8'h0B;
  localparam logic [7:0]  TYPE_FAT32_LBA = 8'h0C;
  localparam logic [15:0] BOOT_SIGNATURE = 16'h55AA;

  typedef enum logic [2:0] {
    ST_MOUNTED     = 3'd0,
    ST_NEED_PART   = 3'd1,
    ST_BAD_SIG     = 3'd2,
    ST_NO_FAT32    = 3'd3,
    ST_BAD_SIZE    = 3'd4,
    ST_BAD_CLUSTER = 3'd5,
    ST_NOT_FAT32   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] partition_lba;
    logic [31:0] fat_base_lba;
    logic [31:0] data_base_lba;
    logic [31:0] root_cluster_out;
    logic [31:0] cluster_count;
    logic [19:0] cluster_bytes;
    logic [12:0] sector_bytes_out;
    logic [7:0]  cluster_sectors_out;
    logic [7:0]  fat_copies_out;
    logic [31:0] fat_length_out;
  } result_t;

  // Everything the back end needs from one finished sector
  typedef struct packed {
    logic        sig_ok;
    logic [15:0] sector_size;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_count;
    logic [7:0]  fat_copies;
    logic        legacy_nonzero;
    logic [31:0] total_sectors;
    logic [31:0] fat_length;
    logic [31:0] root_start;
    logic [31:0] candidate_lba;
    logic        found_partition;
  } sector_sum_t;

  function automatic logic size_ok(input logic [15:0] s);
    return (s == 16'd512) || (s == 16'd1024) || (s == 16'd2048) || (s == 16'd4096);
  endfunction

  // Shift amount for a one-hot sectors-per-cluster value
  function automatic logic [2:0] cluster_shift(input logic [7:0] cs);
    logic [2:0] sh;
    case (cs)
      8'd2:    sh = 3'd1;
      8'd4:    sh = 3'd2;
      8'd8:    sh = 3'd3;
      8'd16:   sh = 3'd4;
      8'd32:   sh = 3'd5;
      8'd64:   sh = 3'd6;
      8'd128:  sh = 3'd7;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

>>> hw/rtl/fbsp_fifo.sv
`timescale 1ns / 1ps

module fbsp_fifo import fbsp_pkg::*; #(
  parameter int DEPTH = FBSP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  sector_sum_t wr_data,
  output logic        full,
  input  logic        rd_en,
  output sector_sum_t rd_data,
  output logic        empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sector_sum_t   mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming summary
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/fbsp_front.sv
`timescale 1ns / 1ps

module fbsp_front import fbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       item,
  output logic        full,
  output logic        sum_push,
  output sector_sum_t sum_data,
  input  logic        sum_full
);

  logic [9:0]  byte_position,    byte_position_next;
  logic [15:0] signature_bytes,  signature_bytes_next;
  logic [15:0] sector_size,      sector_size_next;
  logic [7:0]  cluster_sectors,  cluster_sectors_next;
  logic [15:0] reserved_count,   reserved_count_next;
  logic [7:0]  fat_copies,       fat_copies_next;
  logic        legacy_nonzero,   legacy_nonzero_next;
  logic [31:0] total_sectors,    total_sectors_next;
  logic [31:0] fat_length,       fat_length_next;
  logic [31:0] root_start,       root_start_next;
  logic        entry_type_match, entry_type_match_next;
  logic [31:0] candidate_lba,    candidate_lba_next;
  logic        found_partition,  found_partition_next;

  logic       accept;
  logic [7:0] b;
  logic [9:0] p;
  logic [9:0] table_off;

  assign full      = sum_full;
  assign accept    = push && !sum_full;
  assign b         = item.data_byte;
  assign p         = byte_position;
  assign table_off = p - POS_PART_TABLE;
  assign sum_push  = accept && item.last_byte;

  // Capture BPB fields and scan the partition table
  always_comb begin
    byte_position_next    = byte_position;
    signature_bytes_next  = signature_bytes;
    sector_size_next      = sector_size;
    cluster_sectors_next  = cluster_sectors;
    reserved_count_next   = reserved_count;
    fat_copies_next       = fat_copies;
    legacy_nonzero_next   = legacy_nonzero;
    total_sectors_next    = total_sectors;
    fat_length_next       = fat_length;
    root_start_next       = root_start;
    entry_type_match_next = entry_type_match;
    candidate_lba_next    = candidate_lba;
    found_partition_next  = found_partition;
    sum_data              = '0;

    if (accept) begin
      if (p < POS_SECTOR_END) begin
        case (p)
          10'd11:  sector_size_next[7:0]     = b;
          10'd12:  sector_size_next[15:8]    = b;
          10'd13:  cluster_sectors_next      = b;
          10'd14:  reserved_count_next[7:0]  = b;
          10'd15:  reserved_count_next[15:8] = b;
          10'd16:  fat_copies_next           = b;
          10'd17, 10'd18, 10'd19, 10'd20, 10'd22, 10'd23: begin
            if (b != 8'd0) legacy_nonzero_next = 1'b1;
          end
          10'd32:  total_sectors_next[7:0]   = b;
          10'd33:  total_sectors_next[15:8]  = b;
          10'd34:  total_sectors_next[23:16] = b;
          10'd35:  total_sectors_next[31:24] = b;
          10'd36:  fat_length_next[7:0]      = b;
          10'd37:  fat_length_next[15:8]     = b;
          10'd38:  fat_length_next[23:16]    = b;
          10'd39:  fat_length_next[31:24]    = b;
          10'd44:  root_start_next[7:0]      = b;
          10'd45:  root_start_next[15:8]     = b;
          10'd46:  root_start_next[23:16]    = b;
          10'd47:  root_start_next[31:24]    = b;
          POS_SIG_LO: signature_bytes_next[15:8] = b;
          POS_SIG_HI: signature_bytes_next[7:0]  = b;
          default: ;
        endcase

        if (p >= POS_PART_TABLE && p < POS_SIG_LO && !found_partition) begin
          case (table_off[3:0])
            4'd4:  entry_type_match_next = (b == TYPE_FAT32_CHS) || (b == TYPE_FAT32_LBA);
            4'd8:  candidate_lba_next[7:0]   = b;
            4'd9:  candidate_lba_next[15:8]  = b;
            4'd10: candidate_lba_next[23:16] = b;
            4'd11: begin
              candidate_lba_next[31:24] = b;
              if (entry_type_match && candidate_lba_next != 32'd0) begin
                found_partition_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      if (byte_position < POS_LAST_COUNT) begin
        byte_position_next = byte_position + 10'd1;
      end

      // Hand the finished sector to the back end and start over
      if (item.last_byte) begin
        sum_data.sig_ok          = (signature_bytes_next == BOOT_SIGNATURE);
        sum_data.sector_size     = sector_size_next;
        sum_data.cluster_sectors = cluster_sectors_next;
        sum_data.reserved_count  = reserved_count_next;
        sum_data.fat_copies      = fat_copies_next;
        sum_data.legacy_nonzero  = legacy_nonzero_next;
        sum_data.total_sectors   = total_sectors_next;
        sum_data.fat_length      = fat_length_next;
        sum_data.root_start      = root_start_next;
        sum_data.candidate_lba   = candidate_lba_next;
        sum_data.found_partition = found_partition_next;

        byte_position_next    = '0;
        signature_bytes_next  = '0;
        sector_size_next      = '0;
        cluster_sectors_next  = '0;
        reserved_count_next   = '0;
        fat_copies_next       = '0;
        legacy_nonzero_next   = 1'b0;
        total_sectors_next    = '0;
        fat_length_next       = '0;
        root_start_next       = '0;
        entry_type_match_next = 1'b0;
        candidate_lba_next    = '0;
        found_partition_next  = 1'b0;
      end
    end
  end

  // Hold sector state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      signature_bytes  <= '0;
      sector_size      <= '0;
      cluster_sectors  <= '0;
      reserved_count   <= '0;
      fat_copies       <= '0;
      legacy_nonzero   <= 1'b0;
      total_sectors    <= '0;
      fat_length       <= '0;
      root_start       <= '0;
      entry_type_match <= 1'b0;
      candidate_lba    <= '0;
      found_partition  <= 1'b0;
    end else begin
      byte_position    <= byte_position_next;
      signature_bytes  <= signature_bytes_next;
      sector_size      <= sector_size_next;
      cluster_sectors  <= cluster_sectors_next;
      reserved_count   <= reserved_count_next;
      fat_copies       <= fat_copies_next;
      legacy_nonzero   <= legacy_nonzero_next;
      total_sectors    <= total_sectors_next;
      fat_length       <= fat_length_next;
      root_start       <= root_start_next;
      entry_type_match <= entry_type_match_next;
      candidate_lba    <= candidate_lba_next;
      found_partition  <= found_partition_next;
    end
  end

endmodule

>>> hw/rtl/fbsp_back.sv
`timescale 1ns / 1ps

module fbsp_back import fbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sum_empty,
  input  sector_sum_t sum_data,
  output logic        sum_pop,
  input  logic        pop,
  output logic        empty,
  output result_t     result
);

  back_state_t state, state_next;

  sector_sum_t work;
  logic        expect_partition;
  logic [31:0] partition_start;
  status_t     status_r;
  status_t     status_calc;
  logic [31:0] part_r;
  logic [31:0] fats_r;
  logic        out_valid;
  result_t     res_next;
  result_t     res;

  logic        load_work;
  logic        load_check;
  logic        load_out;

  logic        cs_ok;
  logic [31:0] fats_full;
  logic [31:0] fat_start;
  logic [31:0] data_span;
  logic [2:0]  shamt;

  assign empty  = !out_valid;
  assign result = res;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (!sum_empty) state_next = BK_CHECK;
      BK_CHECK:  state_next = BK_FINISH;
      BK_FINISH: if (!out_valid || pop) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // Step strobes
  always_comb begin
    load_work  = 1'b0;
    load_check = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE:   load_work  = !sum_empty;
      BK_CHECK:  load_check = 1'b1;
      BK_FINISH: load_out   = !out_valid || pop;
      default:   ;
    endcase
  end

  assign sum_pop = load_work;

  // Classify the sector
  assign cs_ok = (work.cluster_sectors != 8'd0) &&
                 ((work.cluster_sectors & (work.cluster_sectors - 8'd1)) == 8'd0);

  always_comb begin
    if (!work.sig_ok) begin
      status_calc = ST_BAD_SIG;
    end else if (!expect_partition && !size_ok(work.sector_size)) begin
      status_calc = work.found_partition ? ST_NEED_PART : ST_NO_FAT32;
    end else if (!size_ok(work.sector_size)) begin
      status_calc = ST_BAD_SIZE;
    end else if (!cs_ok) begin
      status_calc = ST_BAD_CLUSTER;
    end else if (work.legacy_nonzero) begin
      status_calc = ST_NOT_FAT32;
    end else begin
      status_calc = ST_MOUNTED;
    end
  end

  assign fats_full = 32'(work.fat_copies) * work.fat_length;

  // Build the result from the registered product
  assign fat_start = part_r + {16'd0, work.reserved_count};
  assign data_span = work.total_sectors - {16'd0, work.reserved_count} - fats_r;
  assign shamt     = cluster_shift(work.cluster_sectors);

  always_comb begin
    res_next        = '0;
    res_next.status = status_r;
    case (status_r)
      ST_MOUNTED: begin
        res_next.partition_lba       = part_r;
        res_next.fat_base_lba        = fat_start;
        res_next.data_base_lba       = fat_start + fats_r;
        res_next.root_cluster_out    = work.root_start;
        res_next.cluster_count       = data_span >> shamt;
        res_next.cluster_bytes       = {4'd0, work.sector_size} << shamt;
        res_next.sector_bytes_out    = work.sector_size[12:0];
        res_next.cluster_sectors_out = work.cluster_sectors;
        res_next.fat_copies_out      = work.fat_copies;
        res_next.fat_length_out      = work.fat_length;
      end
      ST_NEED_PART: res_next.partition_lba = part_r;
      default: ;
    endcase
  end

  // Take a sector from the queue
  always_ff @(posedge clk) begin
    if (load_work) begin
      work <= sum_data;
    end
  end

  // Register the verdict and the FAT area size
  always_ff @(posedge clk) begin
    if (load_check) begin
      status_r <= status_calc;
      fats_r   <= fats_full;
      if (status_calc == ST_NEED_PART) begin
        part_r <= work.candidate_lba;
      end else begin
        part_r <= expect_partition ? partition_start : 32'd0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      res <= res_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= BK_IDLE;
      expect_partition <= 1'b0;
      partition_start  <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (load_check) begin
        if (status_calc == ST_NEED_PART) begin
          expect_partition <= 1'b1;
          partition_start  <= work.candidate_lba;
        end else begin
          expect_partition <= 1'b0;
          partition_start  <= '0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/fat32_boot_sector_parser_top.sv
`timescale 1ns / 1ps
`include "fat32_boot_sector_parser_top_macros.svh"

// FAT32 boot sector parser. Push one sector byte per cycle from offset 0 and
// mark the final byte with last_byte; one result per sector appears on the
// result output. The front end takes a byte every cycle while the summary
// queue has room and never waits on a sector in progress; a finished sector's
// summary goes into a queue of QUEUE_DEPTH entries, and full rises only while
// that queue is full. The back end takes one summary at a time and steps
// through dequeue, classify with the FAT-size multiply and build the result,
// holding the last step until the result slot is free. A first sector whose
// sector-size field is invalid is read as an MBR: with a FAT32 entry, status 1
// reports the partition start and the next sector is taken as its boot sector.
module fat32_boot_sector_parser_top import fbsp_pkg::*; #(
  parameter int QUEUE_DEPTH = FBSP_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   item,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  logic        q_push;
  sector_sum_t q_wdata;
  logic        q_full;
  logic        q_pop;
  sector_sum_t q_rdata;
  logic        q_empty;

  // Byte capture
  fbsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .sum_push (q_push),
    .sum_data (q_wdata),
    .sum_full (q_full)
  );

  // Sector summary queue
  fbsp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Validation and geometry
  fbsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .sum_empty (q_empty),
    .sum_data  (q_rdata),
    .sum_pop   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  `FBSP_ASSERT_NEXT(a_last_queued, clk, rst, push && !full && item.last_byte, !q_empty)
  `FBSP_ASSERT_NOW(a_need_part_fields, clk, rst, !empty && result.status == ST_NEED_PART, result.partition_lba != 32'd0 && result.fat_base_lba == 32'd0 && result.sector_bytes_out == 13'd0)
  `FBSP_ASSERT_NOW(a_error_fields, clk, rst, !empty && result.status != ST_MOUNTED && result.status != ST_NEED_PART, result.partition_lba == 32'd0 && result.cluster_bytes == 20'd0)
  `FBSP_ASSERT_NOW(a_mounted_size, clk, rst, !empty && result.status == ST_MOUNTED, result.sector_bytes_out == 13'd512 || result.sector_bytes_out == 13'd1024 || result.sector_bytes_out == 13'd2048 || result.sector_bytes_out == 13'd4096)

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fbsp_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  item_t   item = '0;
  logic    full;
  logic    pop = 1'b0;
  logic    empty;
  result_t result;

  fat32_boot_sector_parser_top dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  always #5 clk = ~clk;

  // Mirror of the parser state
  logic [9:0]  byte_pos = '0;
  logic        want_part = 1'b0;
  logic [31:0] part_base = '0;
  logic [15:0] sig_word = '0;
  logic [15:0] sect_size = '0;
  logic [7:0]  clus_sects = '0;
  logic [15:0] rsvd_sects = '0;
  logic [7:0]  fat_count = '0;
  logic        legacy_seen = 1'b0;
  logic [31:0] vol_sectors = '0;
  logic [31:0] fat_sectors = '0;
  logic [31:0] root_clus = '0;
  logic        type_hit = 1'b0;
  logic [31:0] cand_lba = '0;
  logic        part_found = 1'b0;

  result_t pending_reports[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int bytes_fed = 0;
  int sectors_fed = 0;
  int reports_checked = 0;
  int status_hits[7];

  logic [7:0] sector_img [0:511];

  function automatic logic valid_size(logic [15:0] s);
    case (s)
      16'd512, 16'd1024, 16'd2048, 16'd4096: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_sector_state();
    byte_pos = '0;
    sig_word = '0;
    sect_size = '0;
    clus_sects = '0;
    rsvd_sects = '0;
    fat_count = '0;
    legacy_seen = 1'b0;
    vol_sectors = '0;
    fat_sectors = '0;
    root_clus = '0;
    type_hit = 1'b0;
    cand_lba = '0;
    part_found = 1'b0;
  endtask

  // Latch BPB fields and scan the partition table for one sector byte
  task automatic absorb_byte(int pi, logic [7:0] b);
    int off;
    if (pi == 11) sect_size[7:0] = b;
    else if (pi == 12) sect_size[15:8] = b;
    else if (pi == 13) clus_sects = b;
    else if (pi == 14) rsvd_sects[7:0] = b;
    else if (pi == 15) rsvd_sects[15:8] = b;
    else if (pi == 16) fat_count = b;
    else if ((pi >= 17 && pi <= 20) || pi == 22 || pi == 23) legacy_seen |= (b != 8'd0);
    else if (pi >= 32 && pi <= 35) vol_sectors[8*(pi-32) +: 8] = b;
    else if (pi >= 36 && pi <= 39) fat_sectors[8*(pi-36) +: 8] = b;
    else if (pi >= 44 && pi <= 47) root_clus[8*(pi-44) +: 8] = b;
    else if (pi == POS_SIG_LO) sig_word[15:8] = b;
    else if (pi == POS_SIG_HI) sig_word[7:0] = b;

    // Stop scanning at the first FAT32 entry with a start sector
    if (pi >= POS_PART_TABLE && pi < POS_SIG_LO && !part_found) begin
      off = (pi - POS_PART_TABLE) % 16;
      if (off == 4) begin
        type_hit = (b == TYPE_FAT32_CHS || b == TYPE_FAT32_LBA);
      end else if (off >= 8 && off <= 11) begin
        cand_lba[8*(off-8) +: 8] = b;
        if (off == 11 && type_hit && cand_lba != 32'd0) part_found = 1'b1;
      end
    end
  endtask

  // Classify the finished sector and queue the report it should produce
  task automatic close_sector();
    result_t     r;
    logic [31:0] base;
    logic [31:0] fats;
    logic [31:0] fat_start;
    logic [31:0] data_secs;
    logic [31:0] clus_bytes;
    r = '0;
    base = want_part ? part_base : 32'd0;
    if (sig_word != BOOT_SIGNATURE) begin
      r.status = ST_BAD_SIG;
    end else if (!want_part && !valid_size(sect_size)) begin
      if (part_found) begin
        r.status = ST_NEED_PART;
        r.partition_lba = cand_lba;
      end else begin
        r.status = ST_NO_FAT32;
      end
    end else if (!valid_size(sect_size)) begin
      r.status = ST_BAD_SIZE;
    end else if (clus_sects == 8'd0 || (clus_sects & (clus_sects - 8'd1)) != 8'd0) begin
      r.status = ST_BAD_CLUSTER;
    end else if (legacy_seen) begin
      r.status = ST_NOT_FAT32;
    end else begin
      fats = fat_count * fat_sectors;
      fat_start = base + rsvd_sects;
      data_secs = vol_sectors - rsvd_sects - fats;
      clus_bytes = sect_size * clus_sects;
      r.status = ST_MOUNTED;
      r.partition_lba = base;
      r.fat_base_lba = fat_start;
      r.data_base_lba = fat_start + fats;
      r.root_cluster_out = root_clus;
      r.cluster_count = data_secs / clus_sects;
      r.cluster_bytes = clus_bytes[19:0];
      r.sector_bytes_out = sect_size[12:0];
      r.cluster_sectors_out = clus_sects;
      r.fat_copies_out = fat_count;
      r.fat_length_out = fat_sectors;
    end

    // A partition hop makes the next sector the volume boot sector
    if (r.status == ST_NEED_PART) begin
      want_part = 1'b1;
      part_base = cand_lba;
    end else begin
      want_part = 1'b0;
      part_base = '0;
    end
    clear_sector_state();
    pending_reports.push_back(r);
  endtask

  task automatic predict_item(item_t it);
    if (byte_pos < POS_SECTOR_END) absorb_byte(int'(byte_pos), it.data_byte);
    if (byte_pos < POS_LAST_COUNT) byte_pos++;
    if (it.last_byte) close_sector();
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_report(result_t got);
    result_t want;
    if (pending_reports.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: result with none expected, expected nothing, actual status %0d",
                 $time, got.status);
      return;
    end
    want = pending_reports.pop_front();
    reports_checked++;
    status_hits[want.status]++;
    cmp_field("status", want.status, got.status);
    cmp_field("partition_lba", want.partition_lba, got.partition_lba);
    cmp_field("fat_base_lba", want.fat_base_lba, got.fat_base_lba);
    cmp_field("data_base_lba", want.data_base_lba, got.data_base_lba);
    cmp_field("root_cluster_out", want.root_cluster_out, got.root_cluster_out);
    cmp_field("cluster_count", want.cluster_count, got.cluster_count);
    cmp_field("cluster_bytes", want.cluster_bytes, got.cluster_bytes);
    cmp_field("sector_bytes_out", want.sector_bytes_out, got.sector_bytes_out);
    cmp_field("cluster_sectors_out", want.cluster_sectors_out, got.cluster_sectors_out);
    cmp_field("fat_copies_out", want.fat_copies_out, got.fat_copies_out);
    cmp_field("fat_length_out", want.fat_length_out, got.fat_length_out);
  endtask

  // Take results; stall at random or hold off for a counted stretch
  always @(posedge clk) begin
    if (!rst && pop && !empty) check_report(result);
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one byte request, idling first at random, and hold it until taken
  task automatic send_byte(logic [7:0] b, logic is_last);
    item_t nx;
    nx.data_byte = b;
    nx.last_byte = is_last;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= nx;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_item(nx);
    bytes_fed++;
  endtask

  // Bytes past the image are filler
  task automatic feed_sector(int len);
    for (int i = 0; i < len; i++)
      send_byte(i < 512 ? sector_img[i] : 8'($urandom), i == len - 1);
    sectors_fed++;
  endtask

  // Drop push and wait for every outstanding report
  task automatic wait_drain();
    push <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic fill_noise();
    foreach (sector_img[i]) sector_img[i] = 8'($urandom);
  endtask

  task automatic put_le(int off, int nbytes, logic [31:0] v);
    for (int i = 0; i < nbytes; i++) sector_img[off + i] = v[8*i +: 8];
  endtask

  task automatic make_bpb(logic [15:0] bps, logic [7:0] spc, logic [15:0] rsvd,
                          logic [7:0] nfats, logic [31:0] tot, logic [31:0] fatsz,
                          logic [31:0] root);
    fill_noise();
    put_le(11, 2, bps);
    sector_img[13] = spc;
    put_le(14, 2, rsvd);
    sector_img[16] = nfats;
    put_le(17, 4, 32'd0);
    put_le(22, 2, 32'd0);
    put_le(32, 4, tot);
    put_le(36, 4, fatsz);
    put_le(44, 4, root);
    sector_img[POS_SIG_LO] = BOOT_SIGNATURE[15:8];
    sector_img[POS_SIG_HI] = BOOT_SIGNATURE[7:0];
  endtask

  // Boot code noise, an invalid sector size and four empty entries
  task automatic make_mbr();
    fill_noise();
    if (valid_size({sector_img[12], sector_img[11]})) sector_img[12] = 8'h00;
    for (int k = 0; k < 4; k++) sector_img[POS_PART_TABLE + 16*k + 4] = 8'h00;
    sector_img[POS_SIG_LO] = BOOT_SIGNATURE[15:8];
    sector_img[POS_SIG_HI] = BOOT_SIGNATURE[7:0];
  endtask

  task automatic set_entry(int idx, logic [7:0] ptype, logic [31:0] lba);
    sector_img[POS_PART_TABLE + 16*idx + 4] = ptype;
    put_le(POS_PART_TABLE + 16*idx + 8, 4, lba);
  endtask

  task automatic random_bpb();
    logic [15:0] bps;
    logic [7:0]  spc;
    logic [7:0]  nfats;
    bps = 16'd512 << $urandom_range(3);
    if ($urandom_range(9) == 0) bps = 16'($urandom);
    spc = 8'd1 << $urandom_range(7);
    if ($urandom_range(9) == 0) spc = 8'($urandom);
    nfats = ($urandom_range(9) < 7) ? 8'($urandom_range(1, 2)) : 8'($urandom);
    make_bpb(bps, spc, 16'($urandom), nfats, $urandom, $urandom, $urandom);
    // Byte 21 is the media byte and is not a legacy field
    if ($urandom_range(9) == 0) sector_img[$urandom_range(17, 23)] = 8'($urandom_range(1, 255));
    if ($urandom_range(14) == 0)
      sector_img[POS_SIG_LO + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
  endtask

  // MBR hop followed by the volume boot sector of the chosen partition
  task automatic test_partition_mount();
    // Skip a non-FAT32 entry and a FAT32 entry with no start sector
    make_mbr();
    set_entry(0, 8'h07, 32'd100);
    set_entry(1, TYPE_FAT32_CHS, 32'd0);
    set_entry(2, TYPE_FAT32_LBA, 32'h0000_8000);
    set_entry(3, TYPE_FAT32_CHS, 32'd5);
    feed_sector(512);
    // Data region underflows, so the cluster count wraps
    make_bpb(16'd4096, 8'd8, 16'd32, 8'd2, 32'h0000_1000, 32'h0000_1000, 32'd2);
    feed_sector(512);
    wait_drain();
  endtask

  // Sectors that end before the signature
  task automatic test_short_sectors();
    make_bpb(16'd512, 8'd8, 16'd32, 8'd2, 32'h0010_0000, 32'h0000_0400, 32'd2);
    feed_sector(1);
    feed_sector(48);
    wait_drain();
  endtask

  // Hold the result side while one-byte sectors pile up and stall the input
  task automatic test_result_backlog();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 400;
    repeat (16) begin
      sector_img[0] = 8'($urandom);
      feed_sector(1);
    end
    wait_drain();
  endtask

  task automatic run_random_phase(int s_idle, int r_stall, int scenarios);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    repeat (scenarios) begin
      random_bpb();
      feed_sector($urandom_range(1, 10));
    end
    wait_drain();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 4);
    run_random_phase(63, 0, 4);
    run_random_phase(0, 63, 4);
    run_random_phase(15, 15, 4);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_partition_mount();
    test_short_sectors();
    test_result_backlog();
    test_random_traffic();
    repeat (20) @(posedge clk);
    $display("Fed %0d sectors (%0d bytes) under four idle mixes plus a held result side.",
             sectors_fed, bytes_fed);
    $display("Checked %0d reports: %0d mounted, %0d partition hops, %0d rejected.",
             reports_checked, status_hits[ST_MOUNTED], status_hits[ST_NEED_PART],
             reports_checked - status_hits[ST_MOUNTED] - status_hits[ST_NEED_PART]);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fbsp_pkg.sv
hw/rtl/fbsp_fifo.sv
hw/rtl/fbsp_front.sv
hw/rtl/fbsp_back.sv
hw/rtl/fat32_boot_sector_parser_top.sv
sim/tb_top.sv
